// ----- hw/rtl/steq_pkg.sv -----
// ----------------------------------------------------------------------------
// steq_pkg: shared types for the stable time-ordered event queue
// Request codes, result status codes and the per-cycle cell command.
// ----------------------------------------------------------------------------
package steq_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain at once.
   typedef struct packed {
      logic insert;
      logic pop;
   } cmd_type;

endpackage

// ----- hw/rtl/steq_cell.sv -----
// ----------------------------------------------------------------------------
// steq_cell: one slot of the sorted shift-register queue
// Holds one key and tag, compares against the inserted key and shifts
// toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module steq_cell #(
   parameter int KEY_WIDTH = 32,
   parameter int TAG_WIDTH = 32
) (
   input  logic                 clock,
   input  steq_pkg::cmd_type    cmd,
   input  logic [KEY_WIDTH-1:0] new_key,
   input  logic [TAG_WIDTH-1:0] new_tag,
   input  logic                 occupied,
   input  logic                 left_le,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic [TAG_WIDTH-1:0] left_tag,
   input  logic [KEY_WIDTH-1:0] right_key,
   input  logic [TAG_WIDTH-1:0] right_tag,
   output logic                 le,
   output logic [KEY_WIDTH-1:0] key,
   output logic [TAG_WIDTH-1:0] tag
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;

   // Entries at or below the new key stay put, so equal keys keep their order.
   assign le  = occupied && (key_ff <= new_key);
   assign key = key_ff;
   assign tag = tag_ff;

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (cmd.insert) begin
         if (!le) begin
            if (left_le) begin
               key_in = new_key;
               tag_in = new_tag;
            end else begin
               key_in = left_key;
               tag_in = left_tag;
            end
         end
      end else if (cmd.pop) begin
         key_in = right_key;
         tag_in = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

// ----- hw/rtl/stable_time_ordered_event_queue.sv -----
// ----------------------------------------------------------------------------
// A result item is registered and presented in the cycle after its request is
// accepted. Throughput: one insert or pop per cycle while result items are taken;
// every cell compares and shifts in parallel, and the result register frees as
// soon as it is taken. Reset clears the entry count and the result valid flag;
// stored keys and tags are not reset and are only read below the entry count.
// ----------------------------------------------------------------------------
// stable_time_ordered_event_queue: bounded stable min-priority queue
// Keeps entries sorted by key in a chain of cells, head in cell zero.
// ----------------------------------------------------------------------------
module stable_time_ordered_event_queue #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32,
   parameter int TAG_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // event_time [31:0], event_tag [63:32]
   input  logic [0:0]  req_tuser,  // req_type [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // head_time [31:0], head_tag [63:32],
                                   // occupancy [70:64], zero [71]
   output logic [1:0]  rsp_tuser   // status [1:0]
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   head_time_ff, head_time_in;
   logic [31:0]   head_tag_ff, head_tag_in;
   logic [6:0]    occ_ff, occ_in;

   logic                 accept, full, empty;
   steq_pkg::cmd_type    cmd;
   logic [KEY_WIDTH-1:0] new_key;
   logic [TAG_WIDTH-1:0] new_tag;

   logic [CAPACITY:0]    le_chain;
   logic [KEY_WIDTH-1:0] cell_key [CAPACITY+1];
   logic [TAG_WIDTH-1:0] cell_tag [CAPACITY+1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign new_key    = KEY_WIDTH'(req_tdata[31:0]);
   assign new_tag    = TAG_WIDTH'(req_tdata[63:32]);

   assign cmd.insert = accept && (req_tuser[0] == steq_pkg::OP_INSERT) && !full;
   assign cmd.pop    = accept && (req_tuser[0] == steq_pkg::OP_POP) && !empty;

   // Cell zero takes a new entry whenever it is not itself kept.
   assign le_chain[0]        = 1'b1;
   assign cell_key[CAPACITY] = '0;
   assign cell_tag[CAPACITY] = '0;

   // Cells are indexed through offset arrays: slot i reads neighbor at i-1/i+1.
   logic [KEY_WIDTH-1:0] left_key [CAPACITY];
   logic [TAG_WIDTH-1:0] left_tag [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_key[i] = '0;
         assign left_tag[i] = '0;
      end else begin : g_body
         assign left_key[i] = cell_key[i-1];
         assign left_tag[i] = cell_tag[i-1];
      end

      steq_cell #(
         .KEY_WIDTH(KEY_WIDTH),
         .TAG_WIDTH(TAG_WIDTH)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .new_key  (new_key),
         .new_tag  (new_tag),
         .occupied (count_ff > CW'(i)),
         .left_le  (le_chain[i]),
         .left_key (left_key[i]),
         .left_tag (left_tag[i]),
         .right_key(cell_key[i+1]),
         .right_tag(cell_tag[i+1]),
         .le       (le_chain[i+1]),
         .key      (cell_key[i]),
         .tag      (cell_tag[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      head_time_in = head_time_ff;
      head_tag_in  = head_tag_ff;
      occ_in       = occ_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         head_time_in = '0;
         head_tag_in  = '0;
         occ_in       = 7'(count_in);
         if (req_tuser[0] == steq_pkg::OP_INSERT) begin
            status_in = full ? steq_pkg::ST_FULL : steq_pkg::ST_OK;
         end else if (empty) begin
            status_in = steq_pkg::ST_EMPTY;
         end else begin
            status_in    = steq_pkg::ST_OK;
            head_time_in = 32'(cell_key[0]);
            head_tag_in  = 32'(cell_tag[0]);
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      head_time_ff <= head_time_in;
      head_tag_ff  <= head_tag_in;
      occ_ff       <= occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, occ_ff, head_tag_ff, head_time_ff};
   assign rsp_tuser  = status_ff;

endmodule

// ----- tb/sv/steq_event_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// steq_event_checker: result checker for the stable time-ordered event queue
// Watches both streams. It keeps its own sorted copy of the queue contents,
// predicts the result of every accepted request and compares each accepted
// result item, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module steq_event_checker #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,  // event_time [31:0], event_tag [63:32]
   input  logic [0:0]  req_tuser,  // req_type [0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,  // head_time [31:0], head_tag [63:32],
                                   // occupancy [70:64], zero [71]
   input  logic [1:0]  rsp_tuser,  // status [1:0]
   output int          mismatches,
   output int          outstanding,
   output int          results_seen,
   output int          full_rejects,
   output int          empty_pops
);

   typedef struct packed {
      steq_pkg::status_type status;
      logic [31:0]          head_time;
      logic [31:0]          head_tag;
      logic [6:0]           occupancy;
   } queue_result_type;

   // Shadow copy of the queue, head in slot zero.
   logic [31:0]      shadow_keys [DEPTH];
   logic [31:0]      shadow_tags [DEPTH];
   int               shadow_len;

   queue_result_type pending_results [$];
   queue_result_type want;
   queue_result_type got;
   int               error_total;
   int               result_total;
   int               reject_total;
   int               empty_total;

   function automatic queue_result_type apply_request(logic op, logic [31:0] key,
                                                      logic [31:0] tag);
      queue_result_type res;
      int               slot;
      res = '{status: steq_pkg::ST_OK, head_time: '0, head_tag: '0, occupancy: '0};
      if (op == steq_pkg::OP_INSERT) begin
         if (shadow_len >= DEPTH) begin
            res.status = steq_pkg::ST_FULL;
         end else begin
            // Equal keys stay behind the ones already stored.
            slot = 0;
            while (slot < shadow_len && shadow_keys[slot] <= key)
               slot++;
            for (int i = shadow_len; i > slot; i--) begin
               shadow_keys[i] = shadow_keys[i - 1];
               shadow_tags[i] = shadow_tags[i - 1];
            end
            shadow_keys[slot] = key;
            shadow_tags[slot] = tag;
            shadow_len++;
         end
      end else begin
         if (shadow_len == 0) begin
            res.status = steq_pkg::ST_EMPTY;
         end else begin
            res.head_time = shadow_keys[0];
            res.head_tag  = shadow_tags[0];
            for (int i = 0; i + 1 < shadow_len; i++) begin
               shadow_keys[i] = shadow_keys[i + 1];
               shadow_tags[i] = shadow_tags[i + 1];
            end
            shadow_len--;
         end
      end
      res.occupancy = 7'(shadow_len);
      return res;
   endfunction

   task automatic check_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", field, expected, actual);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_len = 0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = steq_pkg::status_type'(rsp_tuser);
            got.head_time = rsp_tdata[31:0];
            got.head_tag  = rsp_tdata[63:32];
            got.occupancy = rsp_tdata[70:64];
            result_total++;
            if (pending_results.size() == 0) begin
               $error("result item with no request waiting (status %0d)", rsp_tuser);
               error_total++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("head_time", want.head_time, got.head_time);
               check_field("head_tag", want.head_tag, got.head_tag);
               check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_request(req_tuser[0], req_tdata[31:0], req_tdata[63:32]);
            if (want.status == steq_pkg::ST_FULL)
               reject_total++;
            if (want.status == steq_pkg::ST_EMPTY)
               empty_total++;
            pending_results.push_back(want);
         end
      end
      mismatches   <= error_total;
      outstanding  <= pending_results.size();
      results_seen <= result_total;
      full_rejects <= reject_total;
      empty_pops   <= empty_total;
   end

endmodule

// ----- tb/sv/tb_stable_time_ordered_event_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_time_ordered_event_queue: testbench top for the event queue
// Drives inserts and pops with random gaps and result back-pressure: a short
// directed sequence, then random mixes, fill-to-full and drain-to-empty runs.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_stable_time_ordered_event_queue;

   localparam int DEPTH = 64;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;  // event_time [31:0], event_tag [63:32]
   logic [0:0]  req_tuser  = steq_pkg::OP_INSERT;  // req_type [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;  // head_time [31:0], head_tag [63:32],
                            // occupancy [70:64], zero [71]
   logic [1:0]  rsp_tuser;  // status [1:0]

   int          mismatches;
   int          outstanding;
   int          results_seen;
   int          full_rejects;
   int          empty_pops;
   int          items_sent = 0;
   bit          steady_flow = 1'b0;

   always #5 clock = ~clock;

   stable_time_ordered_event_queue #(
      .CAPACITY(DEPTH), .KEY_WIDTH(32), .TAG_WIDTH(32)
   ) dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   steq_event_checker #(.DEPTH(DEPTH)) u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .mismatches, .outstanding, .results_seen, .full_rejects, .empty_pops
   );

   // Returns at the edge where the item is taken, with valid still high, so a
   // following item with no gap keeps the stream busy.
   task automatic send_request(logic op, logic [31:0] key, logic [31:0] tag);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {tag, key};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Favors a few repeated times so that equal keys are common.
   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return {16'($urandom_range(0, 3)), 16'h0000};
         default: return $urandom();
      endcase
   endfunction

   task automatic run_mix(int count, int insert_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < insert_pct)
            send_request(steq_pkg::OP_INSERT, pick_key(), $urandom());
         else
            send_request(steq_pkg::OP_POP, $urandom(), $urandom());
      end
   endtask

   // Result side: a random stall before each item, sometimes none at all.
   initial begin
      int stall;
      @(posedge clock iff !reset);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      #2_000_000;
      $display("stable_time_ordered_event_queue test failed");
      $finish;
   end

   initial begin
      int wait_cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pop, extreme keys and tags, ties in arrival order.
      send_request(steq_pkg::OP_POP, 32'h1234_5678, 32'h9ABC_DEF0);
      send_request(steq_pkg::OP_INSERT, 32'h0001_0000, 32'h0000_00A1);
      send_request(steq_pkg::OP_INSERT, 32'h0001_0000, 32'h0000_00A2);
      send_request(steq_pkg::OP_INSERT, 32'h0000_8000, 32'h0000_00A3);
      send_request(steq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(steq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_request(steq_pkg::OP_INSERT, 32'h0001_0000, 32'h0000_00A4);
      send_request(steq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0005);
      for (int i = 0; i < 8; i++)
         send_request(steq_pkg::OP_POP, 32'h0, 32'h0);
      send_request(steq_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000);
      send_request(steq_pkg::OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain_results();

      // Random mix, first without any idling, then with random gaps.
      steady_flow = 1'b1;
      run_mix(40, 60);
      steady_flow = 1'b0;
      run_mix(160, 50);

      // Fill past capacity so inserts get rejected, then drain past empty.
      run_mix(70, 100);
      run_mix(70, 0);
      drain_results();

      run_mix(150, 70);
      steady_flow = 1'b1;
      run_mix(30, 30);
      steady_flow = 1'b0;
      run_mix(120, 30);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (outstanding != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);

      $display("Sent %0d requests and checked %0d result items.", items_sent, results_seen);
      $display("Rejected inserts on a full queue: %0d, pops on an empty queue: %0d.",
               full_rejects, empty_pops);
      if (mismatches == 0 && outstanding == 0) begin
         $display("stable_time_ordered_event_queue test passed");
      end else begin
         $display("stable_time_ordered_event_queue test failed");
      end
      $finish;
   end

endmodule
